// ===== design/pfa_pkg.sv =====
`default_nettype none
package pfa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);
  localparam int ID_BITS        = 16;
  localparam int RAM_WIDTH      = ID_BITS + SIZE_BITS;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_BEST  = 2'd2;
  localparam logic [1:0] MODE_WORST = 2'd3;

  localparam logic [1:0] REG_FIT_MODE     = 2'd0;
  localparam logic [1:0] REG_MIN_LEFTOVER = 2'd1;
  localparam logic [1:0] REG_PART_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic        command;
    logic [3:0]  entry_index;
    logic [15:0] entry_id;
    logic [15:0] entry_capacity;
    logic [15:0] request_size;
  } item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_index;
    logic [15:0] chosen_id;
    logic [15:0] remaining_after;
  } result_t;

  typedef struct packed {
    logic [1:0]  fit_mode;
    logic [15:0] min_leftover;
    logic [4:0]  partition_count;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/pfa_ram.sv =====
`default_nettype none
module pfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/pfa_scan.sv =====
`default_nettype none
module pfa_scan (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pfa_pkg::item_t  in_item,
  input  wire pfa_pkg::cfg_t   cfg,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output pfa_pkg::result_t     res
);
  import pfa_pkg::*;

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic                  rvalid, rvalid_next;
  logic [IDX_BITS-1:0]   raddr_q;
  logic                  found, found_next;
  logic [IDX_BITS-1:0]   pick, pick_next;
  logic [SIZE_BITS-1:0]  best_free, best_free_next;
  logic [ID_BITS-1:0]    best_id, best_id_next;
  logic [IDX_BITS-1:0]   ptr, ptr_next;
  logic [SIZE_BITS-1:0]  req, req_next;

  logic [CNT_BITS-1:0]   n;
  logic [CNT_BITS-1:0]   start;
  logic [CNT_BITS:0]     addr_sum;
  logic [IDX_BITS-1:0]   raddr;
  logic                  we;
  logic [IDX_BITS-1:0]   waddr;
  logic [RAM_WIDTH-1:0]  wdata;
  logic [RAM_WIDTH-1:0]  rdata;
  logic [SIZE_BITS-1:0]  rd_free;
  logic [ID_BITS-1:0]    rd_id;
  logic                  take;
  logic [SIZE_BITS-1:0]  diff;
  logic [SIZE_BITS-1:0]  rem;
  logic [CNT_BITS:0]     np;

  pfa_ram #(
    .WIDTH(RAM_WIDTH),
    .DEPTH(MAX_PARTITIONS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_free = rdata[SIZE_BITS-1:0];
  assign rd_id   = rdata[RAM_WIDTH-1:SIZE_BITS];

  always_comb begin
    if (32'(cfg.partition_count) > MAX_PARTITIONS) begin
      n = CNT_BITS'(MAX_PARTITIONS);
    end else begin
      n = CNT_BITS'(cfg.partition_count);
    end
    if (cfg.fit_mode == MODE_NEXT && CNT_BITS'(ptr) < n) begin
      start = CNT_BITS'(ptr);
    end else begin
      start = '0;
    end
    addr_sum = (CNT_BITS + 1)'(start) + (CNT_BITS + 1)'(cnt);
    if (addr_sum >= (CNT_BITS + 1)'(n)) begin
      addr_sum = addr_sum - (CNT_BITS + 1)'(n);
    end
    raddr = IDX_BITS'(addr_sum);
  end

  // remainder after the grant, cleared at or below the leftover threshold
  always_comb begin
    diff = best_free - req;
    if (32'(diff) <= 32'(cfg.min_leftover)) begin
      rem = '0;
    end else begin
      rem = diff;
    end
    np = (CNT_BITS + 1)'(pick) + 1'b1;
    if (np >= (CNT_BITS + 1)'(n)) begin
      np = '0;
    end
  end

  always_comb begin
    take = 1'b0;
    if (rvalid && req <= rd_free) begin
      if (!found) begin
        take = 1'b1;
      end else if (cfg.fit_mode == MODE_BEST && rd_free < best_free) begin
        take = 1'b1;
      end else if (cfg.fit_mode == MODE_WORST && rd_free > best_free) begin
        take = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rvalid <= 1'b0;
      ptr    <= '0;
      cnt    <= '0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= rvalid_next;
      ptr    <= ptr_next;
      cnt    <= cnt_next;
      found  <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    raddr_q   <= raddr;
    pick      <= pick_next;
    best_free <= best_free_next;
    best_id   <= best_id_next;
    req       <= req_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    rvalid_next    = 1'b0;
    found_next     = found;
    pick_next      = pick;
    best_free_next = best_free;
    best_id_next   = best_id;
    ptr_next       = ptr;
    req_next       = req;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    we             = 1'b0;
    waddr          = IDX_BITS'(in_item.entry_index);
    wdata          = {ID_BITS'(in_item.entry_id), SIZE_BITS'(in_item.entry_capacity)};
    res            = '0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.command == CMD_LOAD) begin
            if (32'(in_item.entry_index) < MAX_PARTITIONS) begin
              we       = 1'b1;
              ptr_next = '0;
            end
          end else begin
            req_next   = SIZE_BITS'(in_item.request_size);
            found_next = 1'b0;
            cnt_next   = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt < n) begin
          cnt_next    = cnt + 1'b1;
          rvalid_next = 1'b1;
        end else begin
          state_next = ST_WRITE;
        end
        if (take) begin
          found_next     = 1'b1;
          pick_next      = raddr_q;
          best_free_next = rd_free;
          best_id_next   = rd_id;
        end
      end
      ST_WRITE: begin
        res_valid = 1'b1;
        if (found) begin
          res.granted         = 1'b1;
          res.chosen_index    = 4'(pick);
          res.chosen_id       = 16'(best_id);
          res.remaining_after = 16'(rem);
        end
        waddr = pick;
        wdata = {best_id, rem};
        if (res_ready) begin
          state_next = ST_IDLE;
          if (found) begin
            we = 1'b1;
            if (cfg.fit_mode == MODE_NEXT) begin
              ptr_next = IDX_BITS'(np);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/partition_fit_allocator.sv =====
// allocate: the result passes from the scan state through the write state to the output register
// the scan reads one table entry per cycle from the partition memory, n = active partition count,
// and the input stays closed until the write state hands the result on to the output register
// a load writes one table entry and gives no result
// rst (synchronous): fit mode first fit, leftover threshold 0, count 16, pointer 0;
// table contents stay undefined until loaded
`default_nettype none
module partition_fit_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index, entry_id, entry_capacity, request_size, zero pad
  input  wire logic [55:0] s_axis_tdata,
  // command
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // chosen_index, chosen_id, remaining_after, zero pad
  output logic      [39:0] m_axis_tdata,
  // granted
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pfa_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    res_valid;
  logic    res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fit_mode        <= MODE_FIRST;
      cfg.min_leftover    <= '0;
      cfg.partition_count <= 5'(MAX_PARTITIONS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIT_MODE:     cfg.fit_mode        <= cfg_data[1:0];
        REG_MIN_LEFTOVER: cfg.min_leftover    <= cfg_data;
        REG_PART_COUNT:   cfg.partition_count <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  assign item.command        = s_axis_tuser;
  assign item.entry_index    = s_axis_tdata[3:0];
  assign item.entry_id       = s_axis_tdata[19:4];
  assign item.entry_capacity = s_axis_tdata[35:20];
  assign item.request_size   = s_axis_tdata[51:36];

  pfa_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (item),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register, refilled on the cycle it drains
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.granted;
  assign m_axis_tdata  = {4'b0, out_res.remaining_after, out_res.chosen_id,
                          out_res.chosen_index};

endmodule
`default_nettype wire

// ===== design/pfa_checker.sv =====
`default_nettype none
module pfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import pfa_pkg::*;

  // an allocate transfer starts a scan, input closes next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_ALLOC) |=> !s_axis_tready)
    else $error("input still open after allocate transfer");

  // after a load transfer the input is ready again in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD) |=> s_axis_tready)
    else $error("input closed after load transfer");

  // refused allocate carries all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == 40'd0)
    else $error("refused result with nonzero fields");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);
`default_nettype wire
